// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the C subset tokenizer
// Lexer modes, token codes and the result item layout.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int IDENT_LIMIT_DEF   = 64;
    localparam int TEXT_LIMIT_DEF    = 256;
    localparam int POSITION_BITS_DEF = 16;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_ESC,
        M_OPER, M_SLASH, M_LINEC, M_BLOCK, M_STAR
    } lex_mode_t;

    localparam logic [5:0] T_EOF     = 6'd0;
    localparam logic [5:0] T_IDENT   = 6'd1;
    localparam logic [5:0] T_NUMBER  = 6'd2;
    localparam logic [5:0] T_STRING  = 6'd3;
    localparam logic [5:0] T_KW_BASE = 6'd4;
    localparam logic [5:0] T_DIVIDE  = 6'd17;
    localparam logic [5:0] T_UNKNOWN = 6'd37;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  text_byte;
        logic [5:0]  token_type;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [7:0]  token_length;
        logic        unterminated;
    } result_t;

    function automatic logic [5:0] single_type(input logic [7:0] c);
        logic [5:0] t;
        unique case (c)
            8'h2B: t = 6'd14;  8'h2D: t = 6'd15;  8'h2A: t = 6'd16;
            8'h2F: t = 6'd17;  8'h25: t = 6'd18;  8'h3D: t = 6'd19;
            8'h3C: t = 6'd22;  8'h3E: t = 6'd24;  8'h21: t = 6'd28;
            8'h3B: t = 6'd29;  8'h2C: t = 6'd30;  8'h28: t = 6'd31;
            8'h29: t = 6'd32;  8'h7B: t = 6'd33;  8'h7D: t = 6'd34;
            8'h5B: t = 6'd35;  8'h5D: t = 6'd36;
            default: t = T_UNKNOWN;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] double_type(input logic [7:0] c);
        logic [5:0] t;
        unique case (c)
            8'h3D: t = 6'd20;  8'h21: t = 6'd21;  8'h3C: t = 6'd23;
            8'h3E: t = 6'd25;  8'h26: t = 6'd26;
            default: t = 6'd27;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/cst_keyword.sv =====
// ----------------------------------------------------------------------------
// cst_keyword: keyword match
// Compares the first identifier bytes and length with the ten keywords.
// ----------------------------------------------------------------------------
module cst_keyword
    import cst_pkg::*;
(
    input  logic [63:0] window,
    input  logic [7:0]  length,
    output logic [5:0]  ident_type
);
    localparam logic [63:0] KW_TEXT [10] = '{
        64'h0000_0000_0074_6E69, 64'h0000_0000_7261_6863,
        64'h0000_0000_6469_6F76, 64'h0000_0000_0000_6669,
        64'h0000_0000_6573_6C65, 64'h0000_0065_6C69_6877,
        64'h0000_0000_0072_6F66, 64'h0000_6E72_7574_6572,
        64'h0000_006B_6165_7262, 64'h6575_6E69_746E_6F63
    };
    localparam logic [7:0] KW_LEN [10] = '{
        8'd3, 8'd4, 8'd4, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6, 8'd5, 8'd8
    };

    always_comb begin
        ident_type = T_IDENT;
        for (int k = 9; k >= 0; k--) begin
            if (length == KW_LEN[k] && window == KW_TEXT[k]) begin
                ident_type = T_KW_BASE + 6'(k);
            end
        end
    end
endmodule

// ===== rtl/c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer: streaming lexer for a small C subset
// Turns source bytes into token value bytes and token-closed items.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one item per cycle while s_tready is high: tuser =
//   kind (1 = end of input), tdata = source byte (byte 0 also ends the input).
//   The m_ channel gives result items: tuser = result_kind, tlast marks the
//   final result of one input item, tdata packs the token fields.
//   Each input item causes zero, one or two results. They are computed in one
//   pass of combinational logic and held in a two-entry output buffer.
//   The first result appears in the cycle after accept. Throughput is one
//   item per cycle while the receiver takes every result; an item that causes
//   two results fills the buffer, and s_tready stays low while it is full.
//   Any number of items with no result pass at one per cycle.
//   At reset the lexer is idle at line 1, column 1 and the buffer is empty.
//   When the receiver stalls, hold results; accept input only while both
//   buffer slots will be free after this cycle's drain.
// ----------------------------------------------------------------------------
module c_subset_tokenizer
    import cst_pkg::*;
#(
    parameter int IDENT_LIMIT   = IDENT_LIMIT_DEF,
    parameter int TEXT_LIMIT    = TEXT_LIMIT_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // text_byte, token_type, start_line,
                                   // start_column, token_length, unterminated
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast
);
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};

    lex_mode_t     mode_reg, mode_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [63:0]   win_reg, win_next;
    logic [PB-1:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [PB-1:0] line_reg, line_next, col_reg, col_next;

    // two-entry result buffer with per-entry last flag
    result_t     buf_reg [2];
    logic        blast_reg [2];
    logic [1:0]  bcnt_reg;

    result_t     res [2];
    logic [1:0]  nres;
    logic [5:0]  kw_type, kw_type_new;

    logic [7:0] c;
    logic       fin, acc;
    assign c   = s_tdata;
    assign fin = s_tuser || (c == 8'd0);

    cst_keyword u_kw (.window(win_reg), .length(cnt_reg), .ident_type(kw_type));
    assign kw_type_new = kw_type;

    function automatic logic is_alpha(input logic [7:0] x);
        return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A);
    endfunction
    function automatic logic is_digit(input logic [7:0] x);
        return x >= 8'h30 && x <= 8'h39;
    endfunction
    function automatic logic is_space(input logic [7:0] x);
        return x == 8'h20 || (x >= 8'd9 && x <= 8'd13);
    endfunction

    always_comb begin
        logic [7:0]    ch;
        logic          close_then_idle;
        logic          do_append;
        logic [7:0]    abyte;
        logic [PB-1:0] sl, sc;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        nres       = 2'd0;
        res[0]     = '0;
        res[1]     = '0;
        close_then_idle = 1'b0;
        do_append  = 1'b0;
        abyte      = c;
        ch         = c;
        sl         = tline_reg;
        sc         = tcol_reg;

        // extend the current token or comment, or close a token as the first result
        unique case (mode_reg)
            M_IDENT: begin
                if (!fin && (is_alpha(c) || is_digit(c) || c == 8'h5F)
                    && cnt_reg < 8'(IDENT_LIMIT - 1)) begin
                    do_append = 1'b1;
                end else begin
                    res[0].token_type   = kw_type_new;
                    res[0].token_length = cnt_reg;
                    nres = 2'd1;
                    close_then_idle = !fin;
                end
            end
            M_NUMBER: begin
                if (!fin && is_digit(c) && cnt_reg < 8'(TEXT_LIMIT - 1)) begin
                    do_append = 1'b1;
                end else begin
                    res[0].token_type   = T_NUMBER;
                    res[0].token_length = cnt_reg;
                    nres = 2'd1;
                    close_then_idle = !fin;
                end
            end
            M_STRING: begin
                if (fin || c == 8'h22 || cnt_reg >= 8'(TEXT_LIMIT - 1)) begin
                    res[0].token_type   = T_STRING;
                    res[0].token_length = cnt_reg;
                    res[0].unterminated = (c != 8'h22) || fin;
                    nres = 2'd1;
                    close_then_idle = !fin && c != 8'h22;
                    mode_next = M_IDLE;
                end else if (c == 8'h5C) begin
                    mode_next = M_ESC;
                end else begin
                    do_append = 1'b1;
                end
            end
            M_ESC: begin
                if (fin) begin
                    res[0].token_type   = T_STRING;
                    res[0].token_length = cnt_reg;
                    res[0].unterminated = 1'b1;
                    nres = 2'd1;
                end else begin
                    do_append = 1'b1;
                    abyte = (c == 8'h6E) ? 8'd10 : (c == 8'h74) ? 8'd9 :
                            (c == 8'h72) ? 8'd13 : c;
                    mode_next = M_STRING;
                end
            end
            M_OPER: begin
                nres = 2'd1;
                if (!fin && c == ((pend_reg == 8'h26 || pend_reg == 8'h7C)
                                  ? pend_reg : 8'h3D)) begin
                    res[0].token_type = double_type(pend_reg);
                end else begin
                    res[0].token_type = single_type(pend_reg);
                    close_then_idle = !fin;
                end
            end
            M_SLASH: begin
                if (!fin && c == 8'h2F) begin
                    mode_next = M_LINEC;
                end else if (!fin && c == 8'h2A) begin
                    mode_next = M_BLOCK;
                end else begin
                    res[0].token_type = T_DIVIDE;
                    nres = 2'd1;
                    close_then_idle = !fin;
                end
            end
            M_LINEC: if (!fin && c == 8'h0A) mode_next = M_IDLE;
            M_BLOCK: if (!fin && c == 8'h2A) mode_next = M_STAR;
            M_STAR: begin
                if (!fin) begin
                    mode_next = (c == 8'h2F) ? M_IDLE : (c == 8'h2A) ? M_STAR : M_BLOCK;
                end
            end
            default: close_then_idle = !fin;
        endcase
        if (nres != 2'd0) begin
            res[0].result_kind  = 1'b1;
            res[0].start_line   = 16'(tline_reg);
            res[0].start_column = 16'(tcol_reg);
            mode_next = M_IDLE;
            pend_next = '0;
            cnt_next  = '0;
            win_next  = '0;
        end

        // lex the byte afresh from idle
        if (close_then_idle && !is_space(ch)) begin
            if (ch == 8'h2F) begin
                mode_next = M_SLASH;
            end else if (is_alpha(ch) || ch == 8'h5F) begin
                mode_next = M_IDENT;
                do_append = 1'b1;
            end else if (is_digit(ch)) begin
                mode_next = M_NUMBER;
                do_append = 1'b1;
            end else if (ch == 8'h22) begin
                mode_next = M_STRING;
            end else if (ch == 8'h3D || ch == 8'h21 || ch == 8'h3C || ch == 8'h3E
                         || ch == 8'h26 || ch == 8'h7C) begin
                mode_next = M_OPER;
                pend_next = ch;
            end
            if (mode_next != M_IDLE) begin
                tline_next = line_reg;
                tcol_next  = col_reg;
                cnt_next   = '0;
                win_next   = '0;
            end else begin
                res[nres[0]] = '0;
                res[nres[0]].result_kind  = 1'b1;
                res[nres[0]].token_type   = single_type(ch);
                res[nres[0]].start_line   = 16'(line_reg);
                res[nres[0]].start_column = 16'(col_reg);
                nres = nres + 2'd1;
            end
        end

        if (do_append) begin
            sl = (close_then_idle) ? line_reg : tline_reg;
            sc = (close_then_idle) ? col_reg : tcol_reg;
            res[nres[0]] = '0;
            res[nres[0]].text_byte    = abyte;
            res[nres[0]].start_line   = 16'(sl);
            res[nres[0]].start_column = 16'(sc);
            nres = nres + 2'd1;
            if (cnt_next < 8'd8) begin
                win_next = win_next | (64'(abyte) << {cnt_next[2:0], 3'b000});
            end
            cnt_next = cnt_next + 8'd1;
        end

        if (fin) begin
            res[nres[0]] = '0;
            res[nres[0]].result_kind  = 1'b1;
            res[nres[0]].token_type   = T_EOF;
            res[nres[0]].start_line   = 16'(line_reg);
            res[nres[0]].start_column = 16'(col_reg);
            nres = nres + 2'd1;
            mode_next  = M_IDLE;
            pend_next  = '0;
            cnt_next   = '0;
            win_next   = '0;
            tline_next = PB'(1);
            tcol_next  = PB'(1);
            line_next  = PB'(1);
            col_next   = PB'(1);
        end else if (c == 8'h0A) begin
            if (line_reg < PMAX) line_next = line_reg + PB'(1);
            col_next = PB'(1);
        end else if (col_reg < PMAX) begin
            col_next = col_reg + PB'(1);
        end
    end

    // buffer control: drain head, accept only into a fully free buffer next cycle
    logic pop;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (bcnt_reg == 2'd0) || (bcnt_reg == 2'd1 && pop);
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            win_reg   <= '0;
            tline_reg <= PB'(1);
            tcol_reg  <= PB'(1);
            line_reg  <= PB'(1);
            col_reg   <= PB'(1);
            bcnt_reg  <= 2'd0;
        end else begin
            if (acc) begin
                mode_reg  <= mode_next;
                pend_reg  <= pend_next;
                cnt_reg   <= cnt_next;
                win_reg   <= win_next;
                tline_reg <= tline_next;
                tcol_reg  <= tcol_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                buf_reg[0]   <= res[0];
                buf_reg[1]   <= res[1];
                blast_reg[0] <= (nres == 2'd1);
                blast_reg[1] <= 1'b1;
                bcnt_reg     <= nres;
            end else if (pop) begin
                buf_reg[0]   <= buf_reg[1];
                blast_reg[0] <= blast_reg[1];
                bcnt_reg     <= bcnt_reg - 2'd1;
            end
        end
    end

    assign m_tvalid = (bcnt_reg != 2'd0);
    assign m_tuser  = buf_reg[0].result_kind;
    assign m_tlast  = blast_reg[0];
    assign m_tdata  = {1'b0, buf_reg[0].unterminated, buf_reg[0].token_length,
                       buf_reg[0].start_column, buf_reg[0].start_line,
                       buf_reg[0].token_type, buf_reg[0].text_byte};

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg != 2'd3) else $error("result buffer overfilled");
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (bcnt_reg == 2'd2) |-> !s_tready) else $error("accepted with full buffer");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result moved");
    a_eof_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && fin) |=> (line_reg == PB'(1) && mode_reg == M_IDLE))
        else $error("end of input left state");
endmodule
